@@ rtl/core/mcsm_pkg.sv @@
`default_nettype none

package mcsm_pkg;

    // element and result value width
    localparam int DATA_W = 32;
    // configuration register width
    localparam int CFG_W = 4;
    // result row and column index width
    localparam int IDX_W = 3;
    // configuration register index width
    localparam int CFG_IDX_W = 1;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 1'b1;

    // size registers after reset
    localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 4'd8;

    // commands from the job controller to the column order unit
    typedef struct packed {
        logic load;       // element accepted: update the column minimum
        logic first_row;  // element is in row 0: minimum restarts
        logic sort;       // final element accepted: start the sort
    } ord_cmd_t;

endpackage

`default_nettype wire

@@ rtl/core/mcsm_order.sv @@
`default_nettype none

// Column key table (minimum and source column) with a selection sort sequencer.
module mcsm_order #(
    parameter int MAX_COLS = 8,
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
    localparam int DEPTH = 1 << CW
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire mcsm_pkg::ord_cmd_t                  cmd,
    input  wire logic [CW-1:0]                       col_sel,
    input  wire logic signed [mcsm_pkg::DATA_W-1:0]  elem,
    input  wire logic [CW:0]                         cols,
    output logic [CW-1:0]                            src_col,
    output logic                                     sort_done
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_SCAN,
        S_SWAP_A,
        S_SWAP_B
    } state_t;

    state_t state_reg;

    logic [CW-1:0] i_reg;
    logic [CW-1:0] j_reg;
    logic [CW-1:0] best_idx_reg;
    logic signed [mcsm_pkg::DATA_W-1:0] best_min_reg;
    logic [CW-1:0] best_col_reg;
    logic signed [mcsm_pkg::DATA_W-1:0] cur_min_reg;
    logic [CW-1:0] cur_col_reg;
    logic sort_done_reg;

    logic signed [mcsm_pkg::DATA_W-1:0] key_min_reg [DEPTH];
    logic [CW-1:0] key_col_reg [DEPTH];

    logic [CW-1:0] rd_idx;
    logic signed [mcsm_pkg::DATA_W-1:0] rd_min;
    logic [CW-1:0] rd_col;

    logic wr_en;
    logic [CW-1:0] wr_idx;
    logic signed [mcsm_pkg::DATA_W-1:0] wr_min;
    logic [CW-1:0] wr_col;

    logic scan_end;
    logic last_pass;

    // single read port of the key table
    always_comb
    begin
        case (state_reg)
            S_INIT:  rd_idx = i_reg;
            S_SCAN:  rd_idx = j_reg;
            default: rd_idx = col_sel;
        endcase
    end

    assign rd_min  = key_min_reg[rd_idx];
    assign rd_col  = key_col_reg[rd_idx];
    assign src_col = rd_col;
    assign sort_done = sort_done_reg;

    assign scan_end  = ({1'b0, j_reg} == (cols - (CW+1)'(1)));
    assign last_pass = (({1'b0, i_reg} + (CW+1)'(2)) == cols);

    // single write port: load update or one half of a swap
    always_comb
    begin
        wr_en  = 1'b0;
        wr_idx = col_sel;
        wr_min = elem;
        wr_col = col_sel;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.load && (cmd.first_row || (elem < rd_min)))
                begin
                    wr_en = 1'b1;
                end
            end
            S_SWAP_A:
            begin
                wr_en  = 1'b1;
                wr_idx = best_idx_reg;
                wr_min = cur_min_reg;
                wr_col = cur_col_reg;
            end
            S_SWAP_B:
            begin
                wr_en  = 1'b1;
                wr_idx = i_reg;
                wr_min = best_min_reg;
                wr_col = best_col_reg;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_min_reg[wr_idx] <= wr_min;
            key_col_reg[wr_idx] <= wr_col;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            best_idx_reg  <= '0;
            best_min_reg  <= '0;
            best_col_reg  <= '0;
            cur_min_reg   <= '0;
            cur_col_reg   <= '0;
            sort_done_reg <= 1'b0;
        end
        else
        begin
            sort_done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd.sort)
                    begin
                        i_reg <= '0;
                        if (cols > (CW+1)'(1))
                        begin
                            state_reg <= S_INIT;
                        end
                        else
                        begin
                            sort_done_reg <= 1'b1;
                        end
                    end
                end
                S_INIT:
                begin
                    cur_min_reg  <= rd_min;
                    cur_col_reg  <= rd_col;
                    best_min_reg <= rd_min;
                    best_col_reg <= rd_col;
                    best_idx_reg <= i_reg;
                    j_reg        <= i_reg + CW'(1);
                    state_reg    <= S_SCAN;
                end
                S_SCAN:
                begin
                    // strict compare: first smallest wins
                    if (rd_min < best_min_reg)
                    begin
                        best_min_reg <= rd_min;
                        best_col_reg <= rd_col;
                        best_idx_reg <= j_reg;
                    end
                    if (scan_end)
                    begin
                        state_reg <= S_SWAP_A;
                    end
                    else
                    begin
                        j_reg <= j_reg + CW'(1);
                    end
                end
                S_SWAP_A:
                begin
                    state_reg <= S_SWAP_B;
                end
                S_SWAP_B:
                begin
                    if (last_pass)
                    begin
                        sort_done_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    else
                    begin
                        i_reg     <= i_reg + CW'(1);
                        state_reg <= S_INIT;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/matrix_column_sort_by_min.sv @@
`default_nettype none

// Loads a rows_in_use x cols_in_use matrix of signed 32-bit elements, one
// transaction per element in row-major order, tracking each column's minimum
// as it goes. After the final element the columns are put in ascending order
// of minimum by selection sort (first strictly smallest of the remaining
// columns is swapped into place, so equal minima are not kept stable), and the
// reordered matrix is sent out row by row with last set on its final element.
// Size registers: 0 acts as 1, values above MAX_ROWS / MAX_COLS are clamped.
// Writing either register while loading restarts the load of the current
// matrix. While loading, element_stall is low and an element is taken
// whenever element_valid is high. The sort's pace is set by the single read
// and write port of the column key table. Each result is then read from the
// matrix memory into a read register and loaded into the output register
// before it is offered; the next result is read only once the current one
// is taken. No element is taken during sort or output.
module matrix_column_sort_by_min #(
    parameter int MAX_ROWS = 8,
    parameter int MAX_COLS = 8
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    // element channel
    input  wire logic                                    element_valid,
    output logic                                         element_stall,
    input  wire logic signed [mcsm_pkg::DATA_W-1:0]      element,
    // result channel
    output logic                                         result_valid,
    input  wire logic                                    result_stall,
    output logic signed [mcsm_pkg::DATA_W-1:0]           value,
    output logic [mcsm_pkg::IDX_W-1:0]                   row_index,
    output logic [mcsm_pkg::IDX_W-1:0]                   col_index,
    output logic                                         last,
    // configuration port
    input  wire logic                                    cfg_write_en,
    input  wire logic [mcsm_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [mcsm_pkg::CFG_W-1:0]              cfg_data
);

    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int AW = RW + CW;
    localparam int MEM_DEPTH = 1 << AW;

    typedef enum logic [1:0] {
        M_LOAD,       // taking elements
        M_SORT,       // column order unit busy
        M_EMIT_CAP,   // memory data arrives, load output register
        M_EMIT_HOLD   // result offered until taken
    } state_t;

    state_t state_reg;

    logic [mcsm_pkg::CFG_W-1:0] rows_cfg_reg;
    logic [mcsm_pkg::CFG_W-1:0] cols_cfg_reg;
    logic [RW:0] rows_eff;
    logic [CW:0] cols_eff;

    // load position
    logic [RW-1:0] row_reg;
    logic [CW-1:0] col_reg;
    // output position
    logic [RW-1:0] er_reg;
    logic [CW-1:0] ec_reg;
    logic [RW-1:0] er_next;
    logic [CW-1:0] ec_next;

    logic out_valid_reg;
    logic signed [mcsm_pkg::DATA_W-1:0] value_reg;
    logic signed [mcsm_pkg::DATA_W-1:0] rdata_reg;

    // matrix store, entry {row, col}
    logic signed [mcsm_pkg::DATA_W-1:0] mem [MEM_DEPTH];

    logic in_acc;
    logic load_last;
    logic emit_last;
    logic [AW-1:0] rd_addr;

    mcsm_pkg::ord_cmd_t ord_cmd;
    logic [CW-1:0] ord_sel;
    logic [CW-1:0] src_col;
    logic sort_done;

    // clamp the size registers to 1 .. max
    always_comb
    begin
        if (rows_cfg_reg == '0)
        begin
            rows_eff = (RW+1)'(1);
        end
        else if (rows_cfg_reg > mcsm_pkg::CFG_W'(MAX_ROWS))
        begin
            rows_eff = (RW+1)'(MAX_ROWS);
        end
        else
        begin
            rows_eff = rows_cfg_reg[RW:0];
        end
    end

    always_comb
    begin
        if (cols_cfg_reg == '0)
        begin
            cols_eff = (CW+1)'(1);
        end
        else if (cols_cfg_reg > mcsm_pkg::CFG_W'(MAX_COLS))
        begin
            cols_eff = (CW+1)'(MAX_COLS);
        end
        else
        begin
            cols_eff = cols_cfg_reg[CW:0];
        end
    end

    assign element_stall = (state_reg != M_LOAD);
    assign in_acc        = element_valid && !element_stall;
    assign load_last     = ({1'b0, row_reg} == (rows_eff - (RW+1)'(1)))
                        && ({1'b0, col_reg} == (cols_eff - (CW+1)'(1)));
    assign emit_last     = ({1'b0, er_reg} == (rows_eff - (RW+1)'(1)))
                        && ({1'b0, ec_reg} == (cols_eff - (CW+1)'(1)));

    assign ord_cmd.load      = in_acc;
    assign ord_cmd.first_row = (row_reg == '0);
    assign ord_cmd.sort      = in_acc && load_last;

    // next output position; the memory is read at it ahead of the output register load
    always_comb
    begin
        er_next = er_reg;
        ec_next = ec_reg;
        case (state_reg)
            M_SORT:
            begin
                if (sort_done)
                begin
                    er_next = '0;
                    ec_next = '0;
                end
            end
            M_EMIT_HOLD:
            begin
                if (!result_stall && !emit_last)
                begin
                    if ({1'b0, ec_reg} == (cols_eff - (CW+1)'(1)))
                    begin
                        ec_next = '0;
                        er_next = er_reg + RW'(1);
                    end
                    else
                    begin
                        ec_next = ec_reg + CW'(1);
                    end
                end
            end
            default:
            begin
                er_next = er_reg;
                ec_next = ec_reg;
            end
        endcase
    end

    assign ord_sel = (state_reg == M_LOAD) ? col_reg : ec_next;
    assign rd_addr = {er_next, src_col};

    mcsm_order #(
        .MAX_COLS (MAX_COLS)
    ) u_order (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (ord_cmd),
        .col_sel   (ord_sel),
        .elem      (element),
        .cols      (cols_eff),
        .src_col   (src_col),
        .sort_done (sort_done)
    );

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            mem[{row_reg, col_reg}] <= element;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == M_EMIT_CAP)
        begin
            value_reg <= rdata_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= M_LOAD;
            rows_cfg_reg  <= mcsm_pkg::CFG_SIZE_RESET;
            cols_cfg_reg  <= mcsm_pkg::CFG_SIZE_RESET;
            row_reg       <= '0;
            col_reg       <= '0;
            er_reg        <= '0;
            ec_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            er_reg <= er_next;
            ec_reg <= ec_next;

            if (cfg_write_en)
            begin
                case (cfg_index)
                    mcsm_pkg::REG_ROWS_IN_USE: rows_cfg_reg <= cfg_data;
                    mcsm_pkg::REG_COLS_IN_USE: cols_cfg_reg <= cfg_data;
                    default:                   rows_cfg_reg <= rows_cfg_reg;
                endcase
            end

            case (state_reg)
                M_LOAD:
                begin
                    if (cfg_write_en)
                    begin
                        // partial matrix is dropped
                        row_reg <= '0;
                        col_reg <= '0;
                    end
                    else if (in_acc)
                    begin
                        if (load_last)
                        begin
                            row_reg   <= '0;
                            col_reg   <= '0;
                            state_reg <= M_SORT;
                        end
                        else if ({1'b0, col_reg} == (cols_eff - (CW+1)'(1)))
                        begin
                            col_reg <= '0;
                            row_reg <= row_reg + RW'(1);
                        end
                        else
                        begin
                            col_reg <= col_reg + CW'(1);
                        end
                    end
                end
                M_SORT:
                begin
                    if (sort_done)
                    begin
                        state_reg <= M_EMIT_CAP;
                    end
                end
                M_EMIT_CAP:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= M_EMIT_HOLD;
                end
                M_EMIT_HOLD:
                begin
                    if (!result_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= emit_last ? M_LOAD : M_EMIT_CAP;
                    end
                end
                default:
                begin
                    state_reg <= M_LOAD;
                end
            endcase
        end
    end

    assign result_valid = out_valid_reg;
    assign value        = value_reg;
    assign row_index    = mcsm_pkg::IDX_W'(er_reg);
    assign col_index    = mcsm_pkg::IDX_W'(ec_reg);
    assign last         = emit_last;

endmodule

`default_nettype wire

@@ rtl/core/mcsm_checker.sv @@
`default_nettype none

module mcsm_checker #(
    parameter int MAX_ROWS = 8,
    parameter int MAX_COLS = 8
) (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                element_stall,
    input wire logic                                result_valid,
    input wire logic                                result_stall,
    input wire logic signed [mcsm_pkg::DATA_W-1:0]  value,
    input wire logic [mcsm_pkg::IDX_W-1:0]          row_index,
    input wire logic [mcsm_pkg::IDX_W-1:0]          col_index,
    input wire logic                                last
);

    // a stalled result keeps its payload
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(value)
            && $stable(row_index) && $stable(col_index) && $stable(last))
        else $error("result changed while stalled");

    // no element taken while the matrix is being sent out
    a_no_load_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> element_stall)
        else $error("element accepted during output");

    // indexes stay inside the configured maximum
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (row_index < MAX_ROWS) && (col_index < MAX_COLS))
        else $error("result index out of range");

    // after the final result the block returns to loading
    a_last_ends_job: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && last |=> !result_valid && !element_stall)
        else $error("output continued after last");

endmodule

bind matrix_column_sort_by_min mcsm_checker #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
) u_mcsm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .element_stall (element_stall),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .value         (value),
    .row_index     (row_index),
    .col_index     (col_index),
    .last          (last)
);

`default_nettype wire
